// File: hw/rtl/cae_pkg.sv
// ----------------------------------------------------------------------------
// cae_pkg
// Shared types and constants for the 8-bit ALU and branch execute block:
// opcodes, flag positions, result kinds and the state and result bundles.
// ----------------------------------------------------------------------------
package cae_pkg;

	localparam int unsigned FL_C = 0;
	localparam int unsigned FL_V = 1;
	localparam int unsigned FL_Z = 2;
	localparam int unsigned FL_N = 3;
	localparam int unsigned FL_I = 4;
	localparam int unsigned FL_H = 5;

	localparam logic [7:0]  OP_ABA = 8'h1B;
	localparam logic [7:0]  OP_CBA = 8'h11;
	localparam logic [7:0]  OP_CLC = 8'h0C;
	localparam logic [7:0]  OP_CLI = 8'h0E;
	localparam logic [7:0]  OP_BSR = 8'h8D;
	localparam logic [3:0]  HN_BRANCH = 4'h2;
	localparam logic [3:0]  LN_BRN = 4'h1;
	localparam logic [3:0]  LN_ADC = 4'h9;
	localparam logic [3:0]  LN_ADD = 4'hB;
	localparam logic [3:0]  LN_AND = 4'h4;
	localparam logic [3:0]  LN_BIT = 4'h5;
	localparam logic [3:0]  LN_ASL = 4'h8;
	localparam logic [3:0]  LN_ASR = 4'h7;
	localparam logic [3:0]  LN_CLR = 4'hF;
	localparam logic [3:0]  HN_ACCA = 4'h4;
	localparam logic [3:0]  HN_ACCB = 4'h5;
	localparam logic [3:0]  HN_INDX = 4'h6;
	localparam logic [1:0]  MODE_IMM = 2'd0;
	localparam logic [1:0]  MODE_EXT = 2'd3;

	localparam logic [15:0] STACK_RESET = 16'h00FF;

	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]  acc_a;
		logic [7:0]  acc_b;
		logic [5:0]  ccr;
		logic [15:0] pc;
		logic [15:0] sp;
	} cpu_state_t;

	typedef struct packed {
		logic [7:0]  cmd;
		logic [7:0]  operand_hi;
		logic [7:0]  operand_lo;
		logic [7:0]  mem_data;
		logic [15:0] index_value;
	} item_t;

	typedef struct packed {
		logic [1:0]  nwr;
		logic [15:0] waddr0;
		logic [7:0]  wdata0;
		logic [15:0] waddr1;
		logic [7:0]  wdata1;
		kind_t       fkind;
		logic [15:0] pc;
		logic [7:0]  acc_a;
		logic [7:0]  acc_b;
		logic [5:0]  ccr;
	} bundle_t;

endpackage

// File: hw/rtl/cae_exec.sv
// ----------------------------------------------------------------------------
// cae_exec
// Single-pass instruction execute: decodes one item against the current
// register state, returns the next state and the bundle of results.
// ----------------------------------------------------------------------------
module cae_exec (
	input  cae_pkg::cpu_state_t st,
	input  cae_pkg::item_t      item,
	output cae_pkg::cpu_state_t nxt,
	output cae_pkg::bundle_t    bnd
);
	import cae_pkg::*;

	typedef struct packed {
		logic [7:0] r;
		logic [5:0] cc;
	} alu_res_t;

	function automatic alu_res_t add8(logic [7:0] x, logic [7:0] y, logic cin,
		logic [5:0] cc);
		logic [8:0] s;
		logic [4:0] hs;
		alu_res_t   o;
		s = {1'b0, x} + {1'b0, y} + {8'd0, cin};
		hs = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, cin};
		o.r = s[7:0];
		o.cc = cc;
		o.cc[FL_C] = s[8];
		o.cc[FL_H] = hs[4];
		o.cc[FL_V] = ~(x[7] ^ y[7]) & (x[7] ^ s[7]);
		o.cc[FL_N] = s[7];
		o.cc[FL_Z] = (s[7:0] == 8'd0);
		return o;
	endfunction

	function automatic alu_res_t shift8(logic [7:0] v, logic left, logic [5:0] cc);
		logic     cbit;
		alu_res_t o;
		if (left) begin
			cbit = v[7];
			o.r = {v[6:0], 1'b0};
		end else begin
			cbit = v[0];
			o.r = {v[7], v[7:1]};
		end
		o.cc = cc;
		o.cc[FL_C] = cbit;
		o.cc[FL_V] = o.r[7] ^ cbit;
		o.cc[FL_N] = o.r[7];
		o.cc[FL_Z] = (o.r == 8'd0);
		return o;
	endfunction

	logic [3:0]  hn;
	logic [3:0]  ln;
	logic [15:0] sext;
	logic [15:0] ea_idx;
	logic [15:0] ea_ext;
	logic [15:0] ret_addr;
	logic        fc, fz, fn, fv;
	logic        taken;
	logic [1:0]  mode;
	logic        useb;
	logic [7:0]  acc;
	logic [7:0]  m_op;
	logic [7:0]  sh_in;
	alu_res_t    ar;
	logic [7:0]  andr;

	assign hn = item.cmd[7:4];
	assign ln = item.cmd[3:0];
	assign sext = {{8{item.operand_hi[7]}}, item.operand_hi};
	assign ea_idx = {8'd0, item.operand_hi} + item.index_value;
	assign ea_ext = {item.operand_hi, item.operand_lo};
	assign ret_addr = st.pc + 16'd2;
	assign fc = st.ccr[FL_C];
	assign fz = st.ccr[FL_Z];
	assign fn = st.ccr[FL_N];
	assign fv = st.ccr[FL_V];
	assign mode = hn[1:0];
	assign useb = hn[2];
	assign acc = useb ? st.acc_b : st.acc_a;
	assign m_op = (mode == MODE_IMM) ? item.operand_hi : item.mem_data;
	assign andr = acc & m_op;
	assign sh_in = (hn == HN_ACCA) ? st.acc_a :
		(hn == HN_ACCB) ? st.acc_b : item.mem_data;

	always_comb begin
		case (ln)
			4'h0:    taken = 1'b1;
			4'h2:    taken = !(fc || fz);
			4'h3:    taken = fc || fz;
			4'h4:    taken = !fc;
			4'h5:    taken = fc;
			4'h6:    taken = !fz;
			4'h7:    taken = fz;
			4'h8:    taken = !fv;
			4'h9:    taken = fv;
			4'hA:    taken = !fn;
			4'hB:    taken = fn;
			4'hC:    taken = (fn == fv);
			4'hD:    taken = (fn != fv);
			4'hE:    taken = !fz && (fn == fv);
			default: taken = fz || (fn != fv);
		endcase
	end

	always_comb begin
		nxt = st;
		bnd = '0;
		bnd.fkind = KIND_DONE;
		ar = '0;
		if (item.cmd == OP_ABA) begin
			ar = add8(st.acc_a, st.acc_b, 1'b0, st.ccr);
			nxt.acc_a = ar.r;
			nxt.ccr = ar.cc;
			nxt.pc = st.pc + 16'd1;
		end else if (item.cmd == OP_CBA) begin
			ar.r = st.acc_a - st.acc_b;
			nxt.ccr[FL_C] = (st.acc_a < st.acc_b);
			nxt.ccr[FL_V] = (st.acc_a[7] ^ st.acc_b[7]) & (st.acc_a[7] ^ ar.r[7]);
			nxt.ccr[FL_N] = ar.r[7];
			nxt.ccr[FL_Z] = (ar.r == 8'd0);
			nxt.pc = st.pc + 16'd1;
		end else if (item.cmd == OP_CLC) begin
			nxt.ccr[FL_C] = 1'b0;
			nxt.pc = st.pc + 16'd1;
		end else if (item.cmd == OP_CLI) begin
			nxt.ccr[FL_I] = 1'b0;
			nxt.pc = st.pc + 16'd1;
		end else if (hn == HN_BRANCH && ln != LN_BRN) begin
			nxt.pc = taken ? (ret_addr + sext) : ret_addr;
		end else if (item.cmd == OP_BSR) begin
			bnd.nwr = 2'd2;
			bnd.waddr0 = st.sp;
			bnd.wdata0 = ret_addr[7:0];
			bnd.waddr1 = st.sp - 16'd1;
			bnd.wdata1 = ret_addr[15:8];
			nxt.sp = st.sp - 16'd2;
			nxt.pc = ret_addr + sext;
		end else if (hn[3] && (ln == LN_ADC || ln == LN_ADD || ln == LN_AND ||
			ln == LN_BIT)) begin
			if (ln == LN_ADC || ln == LN_ADD) begin
				ar = add8(acc, m_op, (ln == LN_ADC) ? fc : 1'b0, st.ccr);
			end else begin
				ar.r = andr;
				ar.cc = st.ccr;
				ar.cc[FL_V] = 1'b0;
				ar.cc[FL_N] = andr[7];
				ar.cc[FL_Z] = (andr == 8'd0);
			end
			nxt.ccr = ar.cc;
			if (ln != LN_BIT) begin
				if (useb) begin
					nxt.acc_b = ar.r;
				end else begin
					nxt.acc_a = ar.r;
				end
			end
			nxt.pc = st.pc + ((mode == MODE_EXT) ? 16'd3 : 16'd2);
		end else if (hn[3:2] == 2'b01 && (ln == LN_ASL || ln == LN_ASR ||
			ln == LN_CLR)) begin
			if (ln == LN_CLR) begin
				ar.r = 8'd0;
				ar.cc = st.ccr;
				ar.cc[FL_N] = 1'b0;
				ar.cc[FL_V] = 1'b0;
				ar.cc[FL_C] = 1'b0;
				ar.cc[FL_Z] = 1'b1;
			end else begin
				ar = shift8(sh_in, ln == LN_ASL, st.ccr);
			end
			nxt.ccr = ar.cc;
			unique case (hn)
				HN_ACCA: begin
					nxt.acc_a = ar.r;
					nxt.pc = st.pc + 16'd1;
				end
				HN_ACCB: begin
					nxt.acc_b = ar.r;
					nxt.pc = st.pc + 16'd1;
				end
				HN_INDX: begin
					bnd.nwr = 2'd1;
					bnd.waddr0 = ea_idx;
					bnd.wdata0 = ar.r;
					nxt.pc = st.pc + 16'd2;
				end
				default: begin
					bnd.nwr = 2'd1;
					bnd.waddr0 = ea_ext;
					bnd.wdata0 = ar.r;
					nxt.pc = st.pc + 16'd3;
				end
			endcase
		end else begin
			bnd.fkind = KIND_INVALID;
		end
		bnd.pc = nxt.pc;
		bnd.acc_a = nxt.acc_a;
		bnd.acc_b = nxt.acc_b;
		bnd.ccr = nxt.ccr;
	end

endmodule

// File: hw/rtl/cpu8_alu_branch_execute.sv
// ----------------------------------------------------------------------------
// cpu8_alu_branch_execute
// Executes one 6800-style instruction per input transfer and returns its
// memory writes followed by a completion or invalid-opcode result.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    cmd operand_hi operand_lo
//                                            mem_data index_value
//   out      output     out_valid/out_stall  kind write_addr write_data pc_out
//                                            acc_a_out acc_b_out ccr_out last
//   cfg      input      cfg_valid/cfg_ready  stack_start
//
// An item is registered on input, executed from the input register and held in the
// result register.
// Throughput is one instruction per cycle while out_stall is low, except that an
// instruction with memory writes holds the result register until all its results (up to 3) are taken.
// Asynchronous reset clears A, B, condition codes and PC; SP resets to 0x00FF.
// out_stall holds the result register; the input register then fills and
// in_stall rises.
// ----------------------------------------------------------------------------
module cpu8_alu_branch_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  cmd,
	input  logic [7:0]  operand_hi,
	input  logic [7:0]  operand_lo,
	input  logic [7:0]  mem_data,
	input  logic [15:0] index_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] write_addr,
	output logic [7:0]  write_data,
	output logic [15:0] pc_out,
	output logic [7:0]  acc_a_out,
	output logic [7:0]  acc_b_out,
	output logic [5:0]  ccr_out,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] stack_start
);
	import cae_pkg::*;

	logic       v_s1;
	item_t      item_s1;
	logic       v_s2;
	logic [1:0] idx_s2;
	bundle_t    bnd_s2;
	cpu_state_t state_q;
	logic [15:0] stack_start_q;
	cpu_state_t state_nxt;
	bundle_t    bnd_nxt;
	logic       in_xfer;
	logic       out_xfer;
	logic       last_entry;
	logic       slot_free;
	logic       load_s2;
	logic       is_write;

	// stack start is only stored; reset loads SP from STACK_RESET and restores the stored default
	assign cfg_ready = 1'b1;

	assign in_xfer = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign last_entry = (idx_s2 == bnd_s2.nwr);
	assign slot_free = !v_s2 || (out_xfer && last_entry);
	assign load_s2 = v_s1 && slot_free;
	assign in_stall = v_s1 && !slot_free;

	cae_exec u_exec (
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.bnd  (bnd_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_start_q <= STACK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			stack_start_q <= stack_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_xfer) begin
			v_s1 <= 1'b1;
		end else if (load_s2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= '{cmd: cmd, operand_hi: operand_hi, operand_lo: operand_lo,
				mem_data: mem_data, index_value: index_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{acc_a: 8'd0, acc_b: 8'd0, ccr: 6'd0, pc: 16'd0,
				sp: STACK_RESET};
		end else if (load_s2) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			idx_s2 <= 2'd0;
		end else if (load_s2) begin
			v_s2 <= 1'b1;
			idx_s2 <= 2'd0;
		end else if (out_xfer && last_entry) begin
			v_s2 <= 1'b0;
			idx_s2 <= 2'd0;
		end else if (out_xfer) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			bnd_s2 <= bnd_nxt;
		end
	end

	assign is_write = (idx_s2 < bnd_s2.nwr);
	assign out_valid = v_s2;
	assign kind = is_write ? KIND_WRITE : bnd_s2.fkind;
	assign write_addr = !is_write ? 16'd0 :
		(idx_s2 == 2'd0) ? bnd_s2.waddr0 : bnd_s2.waddr1;
	assign write_data = !is_write ? 8'd0 :
		(idx_s2 == 2'd0) ? bnd_s2.wdata0 : bnd_s2.wdata1;
	assign pc_out = is_write ? 16'd0 : bnd_s2.pc;
	assign acc_a_out = is_write ? 8'd0 : bnd_s2.acc_a;
	assign acc_b_out = is_write ? 8'd0 : bnd_s2.acc_b;
	assign ccr_out = is_write ? 6'd0 : bnd_s2.ccr;
	assign last = !is_write;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (idx_s2 <= bnd_s2.nwr))
		else $error("result index beyond bundle");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != KIND_WRITE)))
		else $error("last does not match result kind");

	a_invalid_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && bnd_nxt.fkind == KIND_INVALID) |=> $stable(state_q))
		else $error("invalid opcode changed state");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (v_s2 && $stable(idx_s2)))
		else $error("stalled result advanced");

	a_sp_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (state_q.sp == stack_start_q))
		else $error("stack pointer reset mismatch");

endmodule

// File: test/cpu8_alu_branch_execute_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_branch_execute_tb
// Self-checking bench for the 8-bit ALU and branch execute block. A directed
// set of instructions and then random instruction streams are driven, all but
// the last with random idle bursts on both channels. An in-bench model of A, B,
// flags, PC and SP predicts every write, completion and invalid result, and each
// result transfer is compared field by field in order.
// ----------------------------------------------------------------------------
module cpu8_alu_branch_execute_tb;
	import cae_pkg::*;

	localparam logic [1:0] MODE_DIR = 2'd1;
	localparam logic [1:0] MODE_IDX = 2'd2;
	localparam logic [3:0] HN_EXTM = 4'h7;
	localparam logic [3:0] LN_BRA = 4'h0;
	localparam logic [3:0] LN_BHI = 4'h2;
	localparam logic [3:0] LN_BLS = 4'h3;
	localparam logic [3:0] LN_BCC = 4'h4;
	localparam logic [3:0] LN_BCS = 4'h5;
	localparam logic [3:0] LN_BNE = 4'h6;
	localparam logic [3:0] LN_BEQ = 4'h7;
	localparam logic [3:0] LN_BVC = 4'h8;
	localparam logic [3:0] LN_BVS = 4'h9;
	localparam logic [3:0] LN_BPL = 4'hA;
	localparam logic [3:0] LN_BMI = 4'hB;
	localparam logic [3:0] LN_BGE = 4'hC;
	localparam logic [3:0] LN_BLT = 4'hD;
	localparam logic [3:0] LN_BGT = 4'hE;
	localparam logic [3:0] LN_BLE = 4'hF;
	localparam logic [7:0] OP_UNUSED = 8'h00;
	localparam logic [7:0] OP_NOT_IMPL = 8'hFF;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] write_addr;
		logic [7:0]  write_data;
		logic [15:0] pc;
		logic [7:0]  acc_a;
		logic [7:0]  acc_b;
		logic [5:0]  ccr;
		logic        last;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  cmd = '0;
	logic [7:0]  operand_hi = '0;
	logic [7:0]  operand_lo = '0;
	logic [7:0]  mem_data = '0;
	logic [15:0] index_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [15:0] write_addr;
	logic [7:0]  write_data;
	logic [15:0] pc_out;
	logic [7:0]  acc_a_out;
	logic [7:0]  acc_b_out;
	logic [5:0]  ccr_out;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] stack_start = '0;

	item_t    instr_queue[$];
	outcome_t predicted[$];

	logic [7:0]  reg_a = '0;
	logic [7:0]  reg_b = '0;
	logic [5:0]  reg_cc = '0;
	logic [15:0] reg_pc = '0;
	logic [15:0] reg_sp = STACK_RESET;
	logic [15:0] stack_start_cfg = STACK_RESET;

	int   idle_pct = 0;
	int   stall_pct = 0;
	int   in_gap = 0;
	int   out_gap = 0;
	logic in_took = 1'b0;
	int   n_instr = 0;
	int   n_invalid = 0;
	int   n_results = 0;
	int   n_writes = 0;
	int   n_fail = 0;

	cpu8_alu_branch_execute DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.operand_hi(operand_hi),
		.operand_lo(operand_lo),
		.mem_data(mem_data),
		.index_value(index_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.write_addr(write_addr),
		.write_data(write_data),
		.pc_out(pc_out),
		.acc_a_out(acc_a_out),
		.acc_b_out(acc_b_out),
		.ccr_out(ccr_out),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.stack_start(stack_start)
	);

	always #5 clk = ~clk;

	function automatic string show(input outcome_t o);
		return $sformatf("kind=%0d addr=%h data=%h pc=%h a=%h b=%h cc=%b last=%b",
			o.kind, o.write_addr, o.write_data, o.pc, o.acc_a, o.acc_b, o.ccr, o.last);
	endfunction

	task automatic flag_error(input string msg);
		n_fail++;
		if (n_fail <= MAX_REPORTS) begin
			$display("%0t ERROR %s", $time, msg);
		end
	endtask

	function automatic outcome_t write_outcome(input logic [15:0] addr, input logic [7:0] data);
		outcome_t o;
		o = '0;
		o.kind = KIND_WRITE;
		o.write_addr = addr;
		o.write_data = data;
		return o;
	endfunction

	function automatic outcome_t state_outcome(input kind_t k, input logic [15:0] pc,
			input logic [7:0] a, input logic [7:0] b, input logic [5:0] cc);
		outcome_t o;
		o = '0;
		o.kind = k;
		o.pc = pc;
		o.acc_a = a;
		o.acc_b = b;
		o.ccr = cc;
		o.last = 1'b1;
		return o;
	endfunction

	// returns {flags, sum}
	function automatic logic [13:0] add_bytes(input logic [7:0] x, input logic [7:0] y,
			input logic cin, input logic [5:0] cc_in);
		logic [8:0] s;
		logic [4:0] h;
		logic [7:0] r;
		logic [5:0] cc;
		s = {1'b0, x} + {1'b0, y} + {8'd0, cin};
		h = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, cin};
		r = s[7:0];
		cc = cc_in;
		cc[FL_C] = s[8];
		cc[FL_H] = h[4];
		cc[FL_V] = (x[7] ~^ y[7]) & (x[7] ^ r[7]);
		cc[FL_N] = r[7];
		cc[FL_Z] = (r == 8'd0);
		return {cc, r};
	endfunction

	function automatic logic [7:0] alu_op(input logic useb, input logic [1:0] mode,
			input logic [3:0] ln);
		return {1'b1, useb, mode, ln};
	endfunction

	task automatic execute_instr(input item_t it);
		logic [7:0]  a, b, r, v, m, acc;
		logic [5:0]  cc;
		logic [15:0] pc, sp, ret, disp;
		logic [3:0]  hn, ln;
		logic [1:0]  mode;
		logic [13:0] sum;
		logic        useb, go, f_c, f_z, f_n, f_v, cbit, known;
		a = reg_a;
		b = reg_b;
		cc = reg_cc;
		pc = reg_pc;
		sp = reg_sp;
		hn = it.cmd[7:4];
		ln = it.cmd[3:0];
		known = 1'b1;
		disp = {{8{it.operand_hi[7]}}, it.operand_hi};
		n_instr++;
		if (it.cmd == OP_ABA) begin
			sum = add_bytes(a, b, 1'b0, cc);
			a = sum[7:0];
			cc = sum[13:8];
			pc = pc + 16'd1;
		end else if (it.cmd == OP_CBA) begin
			r = a - b;
			cc[FL_C] = (a < b);
			cc[FL_V] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
			cc[FL_N] = r[7];
			cc[FL_Z] = (r == 8'd0);
			pc = pc + 16'd1;
		end else if (it.cmd == OP_CLC) begin
			cc[FL_C] = 1'b0;
			pc = pc + 16'd1;
		end else if (it.cmd == OP_CLI) begin
			cc[FL_I] = 1'b0;
			pc = pc + 16'd1;
		end else if (hn == HN_BRANCH && ln != LN_BRN) begin
			f_c = cc[FL_C];
			f_z = cc[FL_Z];
			f_n = cc[FL_N];
			f_v = cc[FL_V];
			case (ln)
				LN_BRA: go = 1'b1;
				LN_BHI: go = !(f_c | f_z);
				LN_BLS: go = f_c | f_z;
				LN_BCC: go = !f_c;
				LN_BCS: go = f_c;
				LN_BNE: go = !f_z;
				LN_BEQ: go = f_z;
				LN_BVC: go = !f_v;
				LN_BVS: go = f_v;
				LN_BPL: go = !f_n;
				LN_BMI: go = f_n;
				LN_BGE: go = (f_n == f_v);
				LN_BLT: go = (f_n != f_v);
				LN_BGT: go = !f_z && (f_n == f_v);
				default: go = f_z || (f_n != f_v);
			endcase
			pc = pc + 16'd2;
			if (go) pc = pc + disp;
		end else if (it.cmd == OP_BSR) begin
			ret = pc + 16'd2;
			predicted.push_back(write_outcome(sp, ret[7:0]));
			predicted.push_back(write_outcome(sp - 16'd1, ret[15:8]));
			sp = sp - 16'd2;
			pc = ret + disp;
		end else if (hn[3] && (ln == LN_ADC || ln == LN_ADD || ln == LN_AND || ln == LN_BIT)) begin
			mode = hn[1:0];
			useb = hn[2];
			acc = useb ? b : a;
			m = (mode == MODE_IMM) ? it.operand_hi : it.mem_data;
			if (ln == LN_ADC || ln == LN_ADD) begin
				sum = add_bytes(acc, m, (ln == LN_ADC) ? cc[FL_C] : 1'b0, cc);
				r = sum[7:0];
				cc = sum[13:8];
			end else begin
				r = acc & m;
				cc[FL_V] = 1'b0;
				cc[FL_N] = r[7];
				cc[FL_Z] = (r == 8'd0);
			end
			if (ln != LN_BIT) begin
				if (useb) b = r;
				else a = r;
			end
			pc = pc + ((mode == MODE_EXT) ? 16'd3 : 16'd2);
		end else if (hn[3:2] == 2'b01 && (ln == LN_ASL || ln == LN_ASR || ln == LN_CLR)) begin
			v = (hn == HN_ACCA) ? a : (hn == HN_ACCB) ? b : it.mem_data;
			if (ln == LN_CLR) begin
				r = 8'd0;
				cc[FL_N] = 1'b0;
				cc[FL_V] = 1'b0;
				cc[FL_C] = 1'b0;
				cc[FL_Z] = 1'b1;
			end else begin
				if (ln == LN_ASL) begin
					cbit = v[7];
					r = {v[6:0], 1'b0};
				end else begin
					cbit = v[0];
					r = {v[7], v[7:1]};
				end
				cc[FL_C] = cbit;
				cc[FL_V] = r[7] ^ cbit;
				cc[FL_N] = r[7];
				cc[FL_Z] = (r == 8'd0);
			end
			case (hn)
				HN_ACCA: begin
					a = r;
					pc = pc + 16'd1;
				end
				HN_ACCB: begin
					b = r;
					pc = pc + 16'd1;
				end
				HN_INDX: begin
					predicted.push_back(write_outcome({8'd0, it.operand_hi} + it.index_value, r));
					pc = pc + 16'd2;
				end
				default: begin
					predicted.push_back(write_outcome({it.operand_hi, it.operand_lo}, r));
					pc = pc + 16'd3;
				end
			endcase
		end else begin
			known = 1'b0;
		end
		if (known) begin
			reg_a = a;
			reg_b = b;
			reg_cc = cc;
			reg_pc = pc;
			reg_sp = sp;
			predicted.push_back(state_outcome(KIND_DONE, pc, a, b, cc));
		end else begin
			n_invalid++;
			predicted.push_back(state_outcome(KIND_INVALID, reg_pc, reg_a, reg_b, reg_cc));
		end
	endtask

	// input side: transfer tracking and prediction; output side: checking
	always @(posedge clk) begin : watch
		outcome_t got, want;
		in_took = in_valid && !in_stall;
		if (arst_n && in_took) begin
			execute_instr(item_t'({cmd, operand_hi, operand_lo, mem_data, index_value}));
		end
		if (arst_n && out_valid && !out_stall) begin
			got = outcome_t'({kind, write_addr, write_data, pc_out, acc_a_out, acc_b_out,
				ccr_out, last});
			n_results++;
			if (got.kind == KIND_WRITE) n_writes++;
			if (predicted.size() == 0) begin
				flag_error({"unexpected result ", show(got)});
			end else begin
				want = predicted.pop_front();
				if (got !== want) begin
					flag_error({"result mismatch\n  expected ", show(want), "\n  actual   ",
						show(got)});
				end
			end
		end
	end

	always @(negedge clk) begin : drive_in
		item_t it;
		if (!in_valid || in_took) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (instr_queue.size() != 0 && $urandom_range(99) < idle_pct) begin
				in_valid <= 1'b0;
				in_gap = $urandom_range(3);
			end else if (instr_queue.size() != 0) begin
				it = instr_queue.pop_front();
				in_valid <= 1'b1;
				cmd <= it.cmd;
				operand_hi <= it.operand_hi;
				operand_lo <= it.operand_lo;
				mem_data <= it.mem_data;
				index_value <= it.index_value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_stall <= 1'b1;
			out_gap--;
		end else if ($urandom_range(99) < stall_pct) begin
			out_stall <= 1'b1;
			out_gap = $urandom_range(3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic add_instr(input logic [7:0] op, input logic [7:0] hi, input logic [7:0] lo,
			input logic [7:0] md, input logic [15:0] x);
		instr_queue.push_back(item_t'({op, hi, lo, md, x}));
	endtask

	task automatic queue_random(input int count);
		item_t it;
		logic [3:0] ln;
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			it.operand_hi = 8'($urandom);
			it.operand_lo = 8'($urandom);
			it.mem_data = 8'($urandom);
			it.index_value = 16'($urandom);
			if (pick < 12) begin
				it.cmd = 8'($urandom);
			end else if (pick < 25) begin
				case ($urandom_range(3))
					0: it.cmd = OP_ABA;
					1: it.cmd = OP_CBA;
					2: it.cmd = OP_CLC;
					default: it.cmd = OP_CLI;
				endcase
			end else if (pick < 45) begin
				it.cmd = {HN_BRANCH, 4'($urandom)};
			end else if (pick < 52) begin
				it.cmd = OP_BSR;
			end else if (pick < 80) begin
				case ($urandom_range(3))
					0: ln = LN_ADC;
					1: ln = LN_ADD;
					2: ln = LN_AND;
					default: ln = LN_BIT;
				endcase
				it.cmd = alu_op(1'($urandom), 2'($urandom), ln);
			end else begin
				case ($urandom_range(2))
					0: ln = LN_ASL;
					1: ln = LN_ASR;
					default: ln = LN_CLR;
				endcase
				it.cmd = {2'b01, 2'($urandom), ln};
			end
			instr_queue.push_back(it);
		end
	endtask

	task automatic write_stack_start(input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		stack_start <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		// never loaded into SP by the block, so the predicted SP keeps its value
		stack_start_cfg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (instr_queue.size() != 0 || in_valid || predicted.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : run
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_stack_start(16'hFFFF);

		idle_pct = 20;
		stall_pct = 20;
		add_instr(OP_CLI, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_instr(alu_op(1'b0, MODE_IMM, LN_ADD), 8'h0F, 8'h00, 8'h00, 16'h0000);
		add_instr(alu_op(1'b0, MODE_IMM, LN_ADD), 8'h01, 8'h00, 8'h00, 16'h0000);
		add_instr(alu_op(1'b0, MODE_IMM, LN_ADD), 8'h70, 8'h00, 8'h00, 16'h0000);
		add_instr(alu_op(1'b1, MODE_DIR, LN_ADD), 8'hFF, 8'h00, 8'h80, 16'h0000);
		add_instr(OP_ABA, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_instr(alu_op(1'b0, MODE_IDX, LN_ADC), 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		add_instr(alu_op(1'b1, MODE_EXT, LN_ADC), 8'hFF, 8'hFF, 8'h7F, 16'hFFFF);
		add_instr(OP_CBA, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_instr(OP_CLC, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_instr(alu_op(1'b0, MODE_IMM, LN_AND), 8'hFF, 8'h00, 8'h00, 16'h0000);
		add_instr(alu_op(1'b1, MODE_EXT, LN_BIT), 8'h12, 8'h34, 8'h00, 16'h0000);
		add_instr(alu_op(1'b1, MODE_IDX, LN_AND), 8'h80, 8'h00, 8'hAA, 16'h8000);
		add_instr({HN_ACCA, LN_ASL}, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_instr({HN_ACCB, LN_ASR}, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_instr({HN_INDX, LN_ASL}, 8'hFF, 8'h00, 8'h81, 16'hFFFF);
		add_instr({HN_EXTM, LN_ASR}, 8'hFF, 8'hFF, 8'h80, 16'h0000);
		add_instr({HN_ACCA, LN_CLR}, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_instr({HN_ACCB, LN_CLR}, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_instr({HN_INDX, LN_CLR}, 8'h01, 8'h00, 8'h55, 16'hFFFF);
		add_instr({HN_EXTM, LN_CLR}, 8'h00, 8'h00, 8'h55, 16'h0000);
		add_instr({HN_BRANCH, LN_BRA}, 8'h80, 8'h00, 8'h00, 16'h0000);
		add_instr({HN_BRANCH, LN_BLE}, 8'h7F, 8'h00, 8'h00, 16'h0000);
		add_instr(OP_BSR, 8'h7F, 8'h00, 8'h00, 16'h0000);
		add_instr(OP_BSR, 8'h80, 8'h00, 8'h00, 16'h0000);
		add_instr({HN_BRANCH, LN_BRN}, 8'h10, 8'h00, 8'h00, 16'h0000);
		add_instr(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		add_instr(OP_NOT_IMPL, 8'h00, 8'h00, 8'h00, 16'h0000);
		settle();

		write_stack_start(16'h0000);
		queue_random(100);
		settle();

		write_stack_start(16'($urandom));
		idle_pct = 40;
		stall_pct = 40;
		queue_random(90);
		settle();

		write_stack_start(16'h8000);
		idle_pct = 0;
		stall_pct = 0;
		queue_random(60);
		settle();
		repeat (8) @(posedge clk);

		if (predicted.size() != 0) flag_error("results still outstanding at end of run");
		$display("ran %0d instructions (%0d invalid opcodes) under four stack_start settings",
			n_instr, n_invalid);
		$display("checked %0d results, %0d of them memory writes, %0d failures",
			n_results, n_writes, n_fail);
		if (n_fail == 0) begin
			$display("cpu8_alu_branch_execute_tb: done, clean");
		end else begin
			$display("cpu8_alu_branch_execute_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", predicted.size());
		$display("cpu8_alu_branch_execute_tb: done, errors");
		$finish;
	end

endmodule

// File: cpu8_alu_branch_execute.f
hw/rtl/cae_pkg.sv
hw/rtl/cae_exec.sv
hw/rtl/cpu8_alu_branch_execute.sv
test/cpu8_alu_branch_execute_tb.sv
